>>> hw/rtl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared codes and controller/datapath interface types for the slab
// free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int HEAD_W   = 16;
    localparam int SIZE_W   = 14;
    localparam int GIVEN_W  = 14;

    localparam logic [HEAD_W-1:0] CHAIN_END = 16'hffff;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 14'd16;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_FORMAT = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_SIZE  = 2'd3;

    typedef struct packed {
        logic latch_in;
        logic exec_en;
        logic rd_done;
        logic fmt_step;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       exec_ok;
        logic       fmt_last;
    } stat_t;

endpackage

>>> hw/rtl/sfla_datapath.sv
// ----------------------------------------------------------------------------
// sfla_datapath
// Chain heads, link memory, format address walker, object size register and
// result register.
// ----------------------------------------------------------------------------
module sfla_datapath #(
    parameter int BLOCK_BYTES = 16384
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sfla_pkg::ctrl_t         ctl,
    output sfla_pkg::stat_t         st,
    input  logic [1:0]              cmd,
    input  logic                    from_owner,
    input  logic [15:0]             object_offset,
    input  logic                    cfg_we,
    input  logic [13:0]             cfg_wdata,
    output logic [1:0]              status,
    output logic [13:0]             given_offset
);
    import sfla_pkg::*;

    localparam int AW    = $clog2(BLOCK_BYTES);
    localparam int IW    = AW - 1;
    localparam int DEPTH = BLOCK_BYTES / 2;
    localparam int SW    = 17;

    logic [HEAD_W-1:0] link_mem [DEPTH];

    logic [HEAD_W-1:0] local_head_reg, local_head_next;
    logic [HEAD_W-1:0] global_head_reg, global_head_next;
    logic [SIZE_W-1:0] size_reg;
    logic [1:0]        cmd_reg;
    logic              owner_reg;
    logic [15:0]       off_reg;
    logic [AW-1:0]     fmt_addr_reg, fmt_addr_next;
    logic [HEAD_W-1:0] rdata_reg;
    logic [1:0]        status_reg, status_next;
    logic [13:0]       given_reg, given_next;

    logic [HEAD_W-1:0] eff_local;
    logic [1:0]        exec_status;
    logic [SW-1:0]     fmt_nxt;
    logic              fmt_last;
    logic              wr_en, rd_en;
    logic [IW-1:0]     wr_idx, rd_idx;
    logic [HEAD_W-1:0] wr_data;

    assign eff_local = (local_head_reg == CHAIN_END) ? global_head_reg : local_head_reg;
    assign fmt_nxt   = SW'(fmt_addr_reg) + SW'(size_reg);
    assign fmt_last  = (fmt_nxt + SW'(size_reg)) > SW'(BLOCK_BYTES);

    always_comb
    begin
        unique case (cmd_reg)
            CMD_ALLOC:
            begin
                if (eff_local == CHAIN_END)
                    exec_status = ST_EMPTY;
                else if (eff_local >= HEAD_W'(BLOCK_BYTES))
                    exec_status = ST_RANGE;
                else
                    exec_status = ST_OK;
            end
            CMD_FREE:
                exec_status = (off_reg >= 16'(BLOCK_BYTES)) ? ST_RANGE : ST_OK;
            CMD_FORMAT:
            begin
                if (size_reg == '0 || size_reg[0] || SW'(size_reg) >= SW'(BLOCK_BYTES))
                    exec_status = ST_SIZE;
                else
                    exec_status = ST_OK;
            end
            default:
                exec_status = ST_OK;
        endcase
    end

    assign st.cmd      = cmd_reg;
    assign st.exec_ok  = (exec_status == ST_OK);
    assign st.fmt_last = fmt_last;

    always_comb
    begin
        local_head_next  = local_head_reg;
        global_head_next = global_head_reg;
        fmt_addr_next    = fmt_addr_reg;
        status_next      = status_reg;
        given_next       = given_reg;
        wr_en            = 1'b0;
        wr_idx           = fmt_addr_reg[AW-1:1];
        wr_data          = CHAIN_END;
        rd_en            = 1'b0;
        rd_idx           = eff_local[AW-1:1];

        if (ctl.exec_en)
        begin
            status_next = exec_status;
            given_next  = '0;
            unique case (cmd_reg)
                CMD_ALLOC:
                begin
                    if (local_head_reg == CHAIN_END)
                    begin
                        local_head_next  = global_head_reg;
                        global_head_next = CHAIN_END;
                    end
                    rd_en = (exec_status == ST_OK);
                end
                CMD_FREE:
                begin
                    if (exec_status == ST_OK)
                    begin
                        wr_en  = 1'b1;
                        wr_idx = off_reg[AW-1:1];
                        if (owner_reg)
                        begin
                            wr_data         = local_head_reg;
                            local_head_next = off_reg;
                        end
                        else
                        begin
                            wr_data          = global_head_reg;
                            global_head_next = off_reg;
                        end
                    end
                end
                CMD_FORMAT:
                    fmt_addr_next = '0;
                default:
                    ;
            endcase
        end

        if (ctl.rd_done)
        begin
            local_head_next = rdata_reg;
            status_next     = ST_OK;
            given_next      = local_head_reg[GIVEN_W-1:0];
        end

        if (ctl.fmt_step)
        begin
            wr_en         = 1'b1;
            wr_data       = fmt_last ? CHAIN_END : fmt_nxt[HEAD_W-1:0];
            fmt_addr_next = fmt_nxt[AW-1:0];
            if (fmt_last)
            begin
                local_head_next = '0;
                status_next     = ST_OK;
                given_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_head_reg  <= CHAIN_END;
            global_head_reg <= CHAIN_END;
            size_reg        <= SIZE_RESET;
        end
        else
        begin
            local_head_reg  <= local_head_next;
            global_head_reg <= global_head_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            cmd_reg   <= cmd;
            owner_reg <= from_owner;
            off_reg   <= object_offset;
        end
        fmt_addr_reg <= fmt_addr_next;
        if (ctl.out_load)
        begin
            status_reg <= status_next;
            given_reg  <= given_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            link_mem[wr_idx] <= wr_data;
        if (rd_en)
            rdata_reg <= link_mem[rd_idx];
    end

    assign status       = status_reg;
    assign given_offset = given_reg;

endmodule

>>> hw/rtl/sfla_ctrl.sv
// ----------------------------------------------------------------------------
// sfla_ctrl
// Command sequencer: input and output handshakes, allocate read wait and
// format walk.
// ----------------------------------------------------------------------------
module sfla_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  sfla_pkg::stat_t  st,
    output sfla_pkg::ctrl_t  ctl
);
    import sfla_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_FMT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch_in = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (st.cmd == CMD_ALLOC && st.exec_ok)
                begin
                    ctl.exec_en = 1'b1;
                    state_next  = S_RD;
                end
                else if (st.cmd == CMD_FORMAT && st.exec_ok)
                begin
                    ctl.exec_en = 1'b1;
                    state_next  = S_FMT;
                end
                else if (slot_free)
                begin
                    ctl.exec_en  = 1'b1;
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RD:
            begin
                if (slot_free)
                begin
                    ctl.rd_done  = 1'b1;
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FMT:
            begin
                if (!st.fmt_last)
                    ctl.fmt_step = 1'b1;
                else if (slot_free)
                begin
                    ctl.fmt_step = 1'b1;
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken beat");

    a_rd_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_RD))
        else $error("read wait entered without an allocate");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.exec_en, ctl.rd_done, ctl.fmt_step}))
        else $error("more than one datapath action in a cycle");

    a_fmt_exit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FMT && state_next == S_IDLE) |-> (ctl.out_load && st.fmt_last))
        else $error("format left without its result");

endmodule

>>> hw/rtl/slab_free_list_allocator.sv
// ----------------------------------------------------------------------------
// slab_free_list_allocator
// Fixed-size object allocator over one block with local and global free
// chains kept in an internal link memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_ready): cmd, from_owner, object_offset.
//   Output beat (out_valid/out_ready): status, given_offset, one per input.
//   cfg_we/cfg_wdata write the slot size register; write only while idle.
//   Steps from input beat to result loaded in the output register:
//     free, format error, allocate with no object, unused cmd: execute only
//     allocate: execute, then one link-memory read
//     format: execute, then one link write per slot
//   The next input beat is taken the cycle after the result is loaded.
//   One command is worked at a time; a new beat is taken each time the
//   sequencer returns to idle, even while the last result is still held.
//   A stalled receiver holds the result; a finished command then waits in
//   its last step until the output register frees up.
//   Reset empties both chains and sets the slot size to 16; link memory is
//   not cleared and must be built by format or frees before use.
// ----------------------------------------------------------------------------
module slab_free_list_allocator #(
    parameter int BLOCK_BYTES = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic        from_owner,
    input  logic [15:0] object_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [13:0] given_offset,
    input  logic        cfg_we,
    input  logic [13:0] cfg_wdata
);
    import sfla_pkg::*;

    ctrl_t ctl;
    stat_t st;

    sfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .ctl       (ctl)
    );

    sfla_datapath #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .st            (st),
        .cmd           (cmd),
        .from_owner    (from_owner),
        .object_offset (object_offset),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .status        (status),
        .given_offset  (given_offset)
    );

endmodule
